[hdl/rpv_pkg.sv]
// shared constants, types and register codes for the region pixel value replacer
package rpv_pkg;

  localparam int COORD_BITS = 16;
  localparam int INDEX_BITS = 14;
  localparam int SIZE_BITS  = INDEX_BITS + 1;
  localparam int PIX_W      = 64;

  // bound width covers x +/- |y| and size - coord without overflow
  localparam int BND_W  = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
  localparam int MAG_W  = BND_W;
  localparam int DIST_W = BND_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int WW_W   = 2 * MAG_W + 1;
  localparam int LPL_W  = SQ_W + MAG_W;
  localparam int LPH_W  = SQ_W + SQ_W - MAG_W;
  localparam int RPL_W  = SQ_W + MAG_W;
  localparam int RPH_W  = SQ_W + WW_W - MAG_W;
  localparam int LHS_W  = 2 * SQ_W;
  localparam int RHS_W  = SQ_W + WW_W;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int REG_LSB = 3;

  localparam logic [PIX_W-1:0] NAN_BITS  = 64'h7FF8_0000_0000_0000;
  localparam logic [PIX_W-1:0] PINF_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [PIX_W-1:0] NINF_BITS = 64'hFFF0_0000_0000_0000;

  // region type bits in mode[1:0]
  localparam int TYPE_OUT_BIT = 0;
  localparam int TYPE_ELL_BIT = 1;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_COORD_ONE   = 3'd1,
    REG_COORD_TWO   = 3'd2,
    REG_COORD_THREE = 3'd3,
    REG_COORD_FOUR  = 3'd4,
    REG_REPLACEMENT = 3'd5,
    REG_WIDTH       = 3'd6,
    REG_HEIGHT      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    STYLE_CORNER = 2'd0,
    STYLE_CENTRE = 2'd1,
    STYLE_BORDER = 2'd2
  } style_t;

  typedef enum logic [1:0] {
    CHOICE_USER = 2'd0,
    CHOICE_NAN  = 2'd1,
    CHOICE_PINF = 2'd2,
    CHOICE_NINF = 2'd3
  } choice_t;

  typedef struct packed {
    logic [5:0]                   mode;
    logic signed [COORD_BITS-1:0] coord_one;
    logic signed [COORD_BITS-1:0] coord_two;
    logic signed [COORD_BITS-1:0] coord_three;
    logic signed [COORD_BITS-1:0] coord_four;
    logic [PIX_W-1:0]             replacement_bits;
    logic [SIZE_BITS-1:0]         image_width;
    logic [SIZE_BITS-1:0]         image_height;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]        pixel;
    logic [PIX_W-1:0]        newv;
    logic [1:0]              rtype;
    logic [INDEX_BITS-1:0]   row;
    logic [INDEX_BITS-1:0]   col;
    logic signed [BND_W-1:0] lf;
    logic signed [BND_W-1:0] rt;
    logic signed [BND_W-1:0] tp;
    logic signed [BND_W-1:0] bt;
  } s1_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [PIX_W-1:0]  newv;
    logic [1:0]        rtype;
    logic              rect_in;
    logic [MAG_W-1:0]  bm;
    logic [DIST_W-1:0] v;
    logic [MAG_W-1:0]  amag;
    logic              aneg;
    logic [DIST_W-1:0] d;
  } s2_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] newv;
    logic [1:0]       rtype;
    logic             rect_in;
    logic             ell_ok;
    logic [SQ_W-1:0]  dd;
    logic [SQ_W-1:0]  bb;
    logic [SQ_W-1:0]  aa;
    logic [WW_W-1:0]  ww;
  } s3_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] newv;
    logic [1:0]       rtype;
    logic             rect_in;
    logic             ell_ok;
    logic [LPL_W-1:0] lp_lo;
    logic [LPH_W-1:0] lp_hi;
    logic [RPL_W-1:0] rp_lo;
    logic [RPH_W-1:0] rp_hi;
  } s4_t;

endpackage

[hdl/rpv_if.sv]
// stream interfaces for pixel items and result items
interface rpv_in_if;
  logic                            valid;
  logic                            ready;
  logic [rpv_pkg::PIX_W-1:0]       pixel_in;
  logic [rpv_pkg::INDEX_BITS-1:0]  row_index;
  logic [rpv_pkg::INDEX_BITS-1:0]  col_index;

  modport source (output valid, pixel_in, row_index, col_index, input ready);
  modport sink (input valid, pixel_in, row_index, col_index, output ready);
endinterface

interface rpv_out_if;
  logic                      valid;
  logic                      ready;
  logic [rpv_pkg::PIX_W-1:0] pixel_out;
  logic                      replaced;

  modport source (output valid, pixel_out, replaced, input ready);
  modport sink (input valid, pixel_out, replaced, output ready);
endinterface

[hdl/region_pixel_value_replacer_unit.sv]
// the result passes through five register stages after the input transfer
// one pixel per cycle while output accepts; a full stage holds while the next cannot load
// the five stages are bounds, distances, squares, partial products, final compare
// stall handling is per stage, so a bubble lets input transfers continue under output stall
// reset clears stage valid bits and sets registers to defaults (image size one by one)
module region_pixel_value_replacer_unit (
  input  logic                       clk,
  input  logic                       rst,
  rpv_in_if.sink                     pix_in,
  rpv_out_if.source                  pix_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rpv_pkg::ADDR_W-1:0] paddr,
  input  logic [rpv_pkg::DATA_W-1:0] pwdata,
  output logic [rpv_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import rpv_pkg::*;

  localparam int NSTAGE = 5;

  cfg_t cfg;
  s2_t  s2;
  s4_t  s4;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;

  rpv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpv_front u_front (
    .clk       (clk),
    .en1       (adv[0]),
    .en2       (adv[1]),
    .cfg       (cfg),
    .pixel_in  (pix_in.pixel_in),
    .row_index (pix_in.row_index),
    .col_index (pix_in.col_index),
    .s2        (s2)
  );

  rpv_mult u_mult (
    .clk (clk),
    .en3 (adv[2]),
    .en4 (adv[3]),
    .s2  (s2),
    .s4  (s4)
  );

  // a stage may load when it is empty or its content moves on
  always_comb begin
    adv[NSTAGE-1] = !vld[NSTAGE-1] || pix_out.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pix_in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  logic [LHS_W-1:0] lhs;
  logic [RHS_W-1:0] rhs;
  logic             ell_in, in_region, hit;
  logic [PIX_W-1:0] pixel_out;
  logic             replaced;

  always_comb begin
    lhs       = LHS_W'(s4.lp_lo) + (LHS_W'(s4.lp_hi) << MAG_W);
    rhs       = RHS_W'(s4.rp_lo) + (RHS_W'(s4.rp_hi) << MAG_W);
    ell_in    = s4.ell_ok && (RHS_W'(lhs) <= rhs);
    in_region = s4.rtype[TYPE_ELL_BIT] ? ell_in : s4.rect_in;
    hit       = s4.rtype[TYPE_OUT_BIT] ? !in_region : in_region;
  end

  always_ff @(posedge clk) begin
    if (adv[NSTAGE-1]) begin
      pixel_out <= hit ? s4.newv : s4.pixel;
      replaced  <= hit;
    end
  end

  assign pix_out.valid     = vld[NSTAGE-1];
  assign pix_out.pixel_out = pixel_out;
  assign pix_out.replaced  = replaced;

endmodule

[hdl/rpv_cfg.sv]
// apb register file holding mode, coordinates, replacement value and image size
module rpv_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpv_pkg::ADDR_W-1:0]   paddr,
  input  logic [rpv_pkg::DATA_W-1:0]   pwdata,
  output logic [rpv_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output rpv_pkg::cfg_t                cfg
);
  import rpv_pkg::*;

  logic [ADDR_W-REG_LSB-1:0] idx;
  logic                      wr;

  assign idx    = paddr[ADDR_W-1:REG_LSB];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode             <= '0;
      cfg.coord_one        <= '0;
      cfg.coord_two        <= '0;
      cfg.coord_three      <= '0;
      cfg.coord_four       <= '0;
      cfg.replacement_bits <= '0;
      cfg.image_width      <= SIZE_BITS'(1);
      cfg.image_height     <= SIZE_BITS'(1);
    end else if (wr) begin
      case (idx)
        REG_MODE:        cfg.mode             <= pwdata[5:0];
        REG_COORD_ONE:   cfg.coord_one        <= signed'(pwdata[COORD_BITS-1:0]);
        REG_COORD_TWO:   cfg.coord_two        <= signed'(pwdata[COORD_BITS-1:0]);
        REG_COORD_THREE: cfg.coord_three      <= signed'(pwdata[COORD_BITS-1:0]);
        REG_COORD_FOUR:  cfg.coord_four       <= signed'(pwdata[COORD_BITS-1:0]);
        REG_REPLACEMENT: cfg.replacement_bits <= pwdata[PIX_W-1:0];
        REG_WIDTH:       cfg.image_width      <= pwdata[SIZE_BITS-1:0];
        REG_HEIGHT:      cfg.image_height     <= pwdata[SIZE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:        prdata = DATA_W'(cfg.mode);
      REG_COORD_ONE:   prdata = DATA_W'(cfg.coord_one);
      REG_COORD_TWO:   prdata = DATA_W'(cfg.coord_two);
      REG_COORD_THREE: prdata = DATA_W'(cfg.coord_three);
      REG_COORD_FOUR:  prdata = DATA_W'(cfg.coord_four);
      REG_REPLACEMENT: prdata = DATA_W'(cfg.replacement_bits);
      REG_WIDTH:       prdata = DATA_W'(cfg.image_width);
      REG_HEIGHT:      prdata = DATA_W'(cfg.image_height);
      default:         prdata = '0;
    endcase
  end

endmodule

[hdl/rpv_front.sv]
// stages one and two: region bounds, rectangle test and ellipse distances
module rpv_front (
  input  logic                           clk,
  input  logic                           en1,
  input  logic                           en2,
  input  rpv_pkg::cfg_t                  cfg,
  input  logic [rpv_pkg::PIX_W-1:0]      pixel_in,
  input  logic [rpv_pkg::INDEX_BITS-1:0] row_index,
  input  logic [rpv_pkg::INDEX_BITS-1:0] col_index,
  output rpv_pkg::s2_t                   s2
);
  import rpv_pkg::*;

  s1_t s1, s1_next;
  s2_t s2_next;

  logic signed [BND_W-1:0] x1, y1, x2, y2, ax2, ay2, wd, ht;

  always_comb begin
    x1  = BND_W'(cfg.coord_one);
    y1  = BND_W'(cfg.coord_two);
    x2  = BND_W'(cfg.coord_three);
    y2  = BND_W'(cfg.coord_four);
    ax2 = (x2 < 0) ? -x2 : x2;
    ay2 = (y2 < 0) ? -y2 : y2;
    wd  = signed'(BND_W'(cfg.image_width));
    ht  = signed'(BND_W'(cfg.image_height));

    s1_next.pixel = pixel_in;
    s1_next.rtype = cfg.mode[1:0];
    s1_next.row   = row_index;
    s1_next.col   = col_index;

    case (style_t'(cfg.mode[3:2]))
      STYLE_CENTRE: begin
        s1_next.lf = x1 - ax2;
        s1_next.rt = x1 + ax2;
        s1_next.tp = y1 - ay2;
        s1_next.bt = y1 + ay2;
      end
      STYLE_BORDER: begin
        s1_next.lf = x1;
        s1_next.rt = wd - x2;
        s1_next.tp = y1;
        s1_next.bt = ht - y2;
      end
      default: begin
        s1_next.lf = (x1 < x2) ? x1 : x2;
        s1_next.rt = (x1 < x2) ? x2 : x1;
        s1_next.tp = (y1 < y2) ? y1 : y2;
        s1_next.bt = (y1 < y2) ? y2 : y1;
      end
    endcase

    case (choice_t'(cfg.mode[5:4]))
      CHOICE_USER: s1_next.newv = cfg.replacement_bits;
      CHOICE_NAN:  s1_next.newv = NAN_BITS;
      CHOICE_PINF: s1_next.newv = PINF_BITS;
      CHOICE_NINF: s1_next.newv = NINF_BITS;
      default:     s1_next.newv = NINF_BITS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= s1_next;
    end
  end

  logic signed [BND_W-1:0] r, c;
  logic signed [BND_W:0]   bdiff, adiff, tsum, lsum;
  logic signed [BND_W+1:0] vdiff, ddiff;
  logic [BND_W:0]          bmag, amag;
  logic [BND_W+1:0]        vmag, dmag;

  // all ellipse quantities in doubled units so the centre stays integral
  always_comb begin
    r     = signed'(BND_W'(s1.row));
    c     = signed'(BND_W'(s1.col));
    bdiff = (BND_W+1)'(s1.bt) - (BND_W+1)'(s1.tp);
    adiff = (BND_W+1)'(s1.rt) - (BND_W+1)'(s1.lf);
    tsum  = (BND_W+1)'(s1.tp) + (BND_W+1)'(s1.bt);
    lsum  = (BND_W+1)'(s1.lf) + (BND_W+1)'(s1.rt);
    vdiff = ((BND_W+2)'(r) <<< 1) - (BND_W+2)'(tsum);
    ddiff = ((BND_W+2)'(c) <<< 1) - (BND_W+2)'(lsum);
    bmag  = bdiff[BND_W] ? -bdiff : bdiff;
    amag  = adiff[BND_W] ? -adiff : adiff;
    vmag  = vdiff[BND_W+1] ? -vdiff : vdiff;
    dmag  = ddiff[BND_W+1] ? -ddiff : ddiff;

    s2_next.pixel   = s1.pixel;
    s2_next.newv    = s1.newv;
    s2_next.rtype   = s1.rtype;
    s2_next.rect_in = (r >= s1.tp) && (r <= s1.bt) && (c >= s1.lf) && (c <= s1.rt);
    s2_next.bm      = bmag[MAG_W-1:0];
    s2_next.amag    = amag[MAG_W-1:0];
    s2_next.aneg    = adiff[BND_W];
    s2_next.v       = vmag[DIST_W-1:0];
    s2_next.d       = dmag[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2 <= s2_next;
    end
  end

endmodule

[hdl/rpv_mult.sv]
// stages three and four: ellipse range checks, squares and split partial products
module rpv_mult (
  input  logic         clk,
  input  logic         en3,
  input  logic         en4,
  input  rpv_pkg::s2_t s2,
  output rpv_pkg::s4_t s4
);
  import rpv_pkg::*;

  s3_t s3, s3_next;
  s4_t s4_next;

  logic [MAG_W-1:0] dm, vm, wlo;
  logic [MAG_W:0]   whi;

  always_comb begin
    dm  = s2.d[MAG_W-1:0];
    vm  = s2.v[MAG_W-1:0];
    wlo = s2.bm - vm;
    whi = (MAG_W+1)'(s2.bm) + (MAG_W+1)'(vm);

    s3_next.pixel   = s2.pixel;
    s3_next.newv    = s2.newv;
    s3_next.rtype   = s2.rtype;
    s3_next.rect_in = s2.rect_in;
    // a reversed width only admits the top and bottom apex
    s3_next.ell_ok  = (s2.bm != '0) && (DIST_W'(s2.bm) >= s2.v) &&
                      (!s2.aneg || (DIST_W'(s2.bm) == s2.v)) &&
                      (DIST_W'(s2.amag) >= s2.d);
    s3_next.dd = SQ_W'(dm) * SQ_W'(dm);
    s3_next.bb = SQ_W'(s2.bm) * SQ_W'(s2.bm);
    s3_next.aa = SQ_W'(s2.amag) * SQ_W'(s2.amag);
    s3_next.ww = WW_W'(wlo) * WW_W'(whi);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3 <= s3_next;
    end
  end

  always_comb begin
    s4_next.pixel   = s3.pixel;
    s4_next.newv    = s3.newv;
    s4_next.rtype   = s3.rtype;
    s4_next.rect_in = s3.rect_in;
    s4_next.ell_ok  = s3.ell_ok;
    s4_next.lp_lo   = LPL_W'(s3.dd) * LPL_W'(s3.bb[MAG_W-1:0]);
    s4_next.lp_hi   = LPH_W'(s3.dd) * LPH_W'(s3.bb[SQ_W-1:MAG_W]);
    s4_next.rp_lo   = RPL_W'(s3.aa) * RPL_W'(s3.ww[MAG_W-1:0]);
    s4_next.rp_hi   = RPH_W'(s3.aa) * RPH_W'(s3.ww[WW_W-1:MAG_W]);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4 <= s4_next;
    end
  end

endmodule

[bench/testbench.sv]
// self-checking testbench for the region pixel value replacer: directed and random pixel streams
module testbench;
  import rpv_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             replaced;
  } pixel_result_t;

  class replace_checker;
    logic [5:0]                   mode;
    logic signed [COORD_BITS-1:0] coord_one, coord_two, coord_three, coord_four;
    logic [PIX_W-1:0]             replacement_bits;
    logic [SIZE_BITS-1:0]         image_width, image_height;
    pixel_result_t                expected_pixels[$];
    int                           mismatches;

    function new();
      mode = '0;
      coord_one = '0;
      coord_two = '0;
      coord_three = '0;
      coord_four = '0;
      replacement_bits = '0;
      image_width = SIZE_BITS'(1);
      image_height = SIZE_BITS'(1);
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_MODE:        mode = val[5:0];
        REG_COORD_ONE:   coord_one = val[COORD_BITS-1:0];
        REG_COORD_TWO:   coord_two = val[COORD_BITS-1:0];
        REG_COORD_THREE: coord_three = val[COORD_BITS-1:0];
        REG_COORD_FOUR:  coord_four = val[COORD_BITS-1:0];
        REG_REPLACEMENT: replacement_bits = val[PIX_W-1:0];
        REG_WIDTH:       image_width = val[SIZE_BITS-1:0];
        REG_HEIGHT:      image_height = val[SIZE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // exact test in doubled units, squared on both sides
    function bit in_ellipse(longint lf, longint rt, longint tp, longint bt,
                            longint r, longint c);
      longint      bm, v, a, d;
      logic [127:0] lhs, rhs;
      bm = mag(bt - tp);
      v  = mag(2 * r - (tp + bt));
      a  = rt - lf;
      d  = mag(2 * c - (lf + rt));
      if (bm == 0 || v > bm) return 1'b0;
      // reversed width leaves only the top or bottom apex
      if (a < 0) begin
        if (v != bm) return 1'b0;
        a = -a;
      end
      if (d > a) return 1'b0;
      lhs = 128'(d) * 128'(d) * 128'(bm) * 128'(bm);
      rhs = 128'(a) * 128'(a) * 128'(bm - v) * 128'(bm + v);
      return lhs <= rhs;
    endfunction

    function void note_input(logic [PIX_W-1:0] pix, logic [INDEX_BITS-1:0] row,
                             logic [INDEX_BITS-1:0] col);
      longint           lf, rt, tp, bt, r, c, x1, y1, x2, y2;
      bit               in_region, hit;
      logic [PIX_W-1:0] subst;
      pixel_result_t    res;
      r  = longint'(row);
      c  = longint'(col);
      x1 = longint'(coord_one);
      y1 = longint'(coord_two);
      x2 = longint'(coord_three);
      y2 = longint'(coord_four);
      case (style_t'(mode[3:2]))
        STYLE_CENTRE: begin
          lf = x1 - mag(x2);
          rt = x1 + mag(x2);
          tp = y1 - mag(y2);
          bt = y1 + mag(y2);
        end
        STYLE_BORDER: begin
          lf = x1;
          rt = longint'(image_width) - x2;
          tp = y1;
          bt = longint'(image_height) - y2;
        end
        default: begin
          // unused style code falls back to corners
          lf = (x1 < x2) ? x1 : x2;
          rt = (x1 < x2) ? x2 : x1;
          tp = (y1 < y2) ? y1 : y2;
          bt = (y1 < y2) ? y2 : y1;
        end
      endcase
      if (mode[TYPE_ELL_BIT])
        in_region = in_ellipse(lf, rt, tp, bt, r, c);
      else
        in_region = (r >= tp) && (r <= bt) && (c >= lf) && (c <= rt);
      hit = mode[TYPE_OUT_BIT] ? !in_region : in_region;
      case (choice_t'(mode[5:4]))
        CHOICE_USER: subst = replacement_bits;
        CHOICE_NAN:  subst = NAN_BITS;
        CHOICE_PINF: subst = PINF_BITS;
        default:     subst = NINF_BITS;
      endcase
      res.pixel    = hit ? subst : pix;
      res.replaced = hit;
      expected_pixels.push_back(res);
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic rep);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel %h replaced %0d", pix, rep);
        return;
      end
      want = expected_pixels.pop_front();
      if (want.pixel !== pix || want.replaced !== rep) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected pixel %h replaced %0d, got pixel %h replaced %0d",
                   want.pixel, want.replaced, pix, rep);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rpv_in_if  in_if();
  rpv_out_if out_if();

  region_pixel_value_replacer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (in_if),
    .pix_out (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  replace_checker checker_h = new();
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             hold_req;
  int             quiet_cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready)
      checker_h.check_result(out_if.pixel_out, out_if.replaced);
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // back-to-back apb writes keep psel high; caller drops it afterwards
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << REG_LSB;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    checker_h.set_reg(idx, val);
  endtask

  task automatic apply_config(logic [5:0] mode, logic [15:0] c1, logic [15:0] c2,
                              logic [15:0] c3, logic [15:0] c4, logic [63:0] repl,
                              logic [14:0] w, logic [14:0] h);
    write_reg(REG_MODE, DATA_W'(mode));
    write_reg(REG_COORD_ONE, DATA_W'(c1));
    write_reg(REG_COORD_TWO, DATA_W'(c2));
    write_reg(REG_COORD_THREE, DATA_W'(c3));
    write_reg(REG_COORD_FOUR, DATA_W'(c4));
    write_reg(REG_REPLACEMENT, repl);
    write_reg(REG_WIDTH, DATA_W'(w));
    write_reg(REG_HEIGHT, DATA_W'(h));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix, logic [INDEX_BITS-1:0] row,
                            logic [INDEX_BITS-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.pixel_in  <= pix;
    in_if.row_index <= row;
    in_if.col_index <= col;
    do @(posedge clk); while (!in_if.ready);
    checker_h.note_input(pix, row, col);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (checker_h.pending() != 0);
  endtask

  task automatic random_config();
    logic [15:0] crd[4];
    logic [14:0] sz[2];
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(4) == 0)
        crd[i] = 16'($urandom);
      else
        crd[i] = 16'($urandom_range(100)) - 16'd10;
    end
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(7))
        0:       sz[i] = 15'd0;
        1:       sz[i] = 15'h7FFF;
        default: sz[i] = 15'($urandom_range(100, 1));
      endcase
    end
    apply_config(6'($urandom_range(63)), crd[0], crd[1], crd[2], crd[3],
                 {$urandom, $urandom}, sz[0], sz[1]);
  endtask

  task automatic random_pixel();
    logic [PIX_W-1:0]      pix;
    logic [INDEX_BITS-1:0] row, col;
    case ($urandom_range(15))
      0:       pix = '0;
      1:       pix = '1;
      default: pix = {$urandom, $urandom};
    endcase
    // mostly near the region, sometimes anywhere in the index range
    row = ($urandom_range(3) == 0) ? INDEX_BITS'($urandom_range(16383))
                                   : INDEX_BITS'($urandom_range(90));
    col = ($urandom_range(3) == 0) ? INDEX_BITS'($urandom_range(16383))
                                   : INDEX_BITS'($urandom_range(90));
    send_pixel(pix, row, col);
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.pixel_in  = '0;
    in_if.row_index = '0;
    in_if.col_index = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    quiet_cycles    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // inside rectangle, corners given in reverse order
    apply_config(6'h00, 16'd5, 16'd6, 16'd2, 16'd3, 64'h0123_4567_89AB_CDEF, 15'd1, 15'd1);
    send_pixel('1, 14'd3, 14'd2);
    send_pixel('0, 14'd6, 14'd5);
    send_pixel(64'h3FF0_0000_0000_0000, 14'd2, 14'd2);
    send_pixel(64'h4000_0000_0000_0000, 14'd7, 14'd5);
    send_pixel(64'hAAAA_5555_AAAA_5555, 14'd16383, 14'd16383);
    drain();

    // outside ellipse, nan; edge point on the ellipse stays
    apply_config(6'h13, 16'd0, 16'd0, 16'd10, 16'd4, 64'd0, 15'd1, 15'd1);
    send_pixel(64'h1111_2222_3333_4444, 14'd2, 14'd5);
    send_pixel(64'h5555_6666_7777_8888, 14'd0, 14'd5);
    send_pixel(64'h9999_AAAA_BBBB_CCCC, 14'd0, 14'd0);
    drain();

    // zero-height ellipse, centre style with negative half width
    apply_config(6'h26, 16'd100, 16'd50, -16'd20, 16'd0, 64'd0, 15'd1, 15'd1);
    send_pixel(64'h0000_0000_0000_0001, 14'd50, 14'd100);
    send_pixel(64'h8000_0000_0000_0000, 14'd50, 14'd90);
    drain();

    // border style with right bound left of left bound: ellipse apex only
    apply_config(6'h3A, 16'd8, 16'd2, 16'd6, 16'd2, 64'd0, 15'd10, 15'd10);
    send_pixel(64'h1234_5678_9ABC_DEF0, 14'd2, 14'd6);
    send_pixel(64'h1234_5678_9ABC_DEF0, 14'd2, 14'd7);
    send_pixel(64'h1234_5678_9ABC_DEF0, 14'd5, 14'd6);
    drain();

    // reversed border bounds with zero image size cover nothing
    apply_config(6'h08, 16'd5, 16'd0, 16'd0, 16'd0, 64'hFFFF_0000_FFFF_0000, 15'd0, 15'd0);
    send_pixel(64'h0F0F_0F0F_0F0F_0F0F, 14'd0, 14'd0);
    send_pixel(64'hF0F0_F0F0_F0F0_F0F0, 14'd0, 14'd5);
    drain();

    // style code three behaves as corners, full coordinate range
    apply_config(6'h0D, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 64'd0, 15'd16384, 15'd16384);
    send_pixel(64'h7FFF_FFFF_FFFF_FFFF, 14'd0, 14'd16383);
    send_pixel(64'hFFFF_FFFF_FFFF_FFFE, 14'd16383, 14'd0);
    drain();

    // centre style at the coordinate extremes
    apply_config(6'h04, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, '1, 15'd1, 15'd1);
    send_pixel(64'h0000_0000_FFFF_FFFF, 14'd0, 14'd0);
    drain();

    // widest ellipse from the border style at maximum image size
    apply_config(6'h0A, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 64'd0, 15'h7FFF, 15'h7FFF);
    send_pixel(64'hDEAD_BEEF_0000_0000, 14'd16383, 14'd16383);
    send_pixel(64'h0000_0000_DEAD_BEEF, 14'd0, 14'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      random_config();
      // long result-side hold while pixels keep coming
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2) drain();
        random_pixel();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
